@@ rtl/ertv_pkg.sv @@
// ----------------------------------------------------------------------------
// ertv_pkg
// Shared constants and helpers for the Euler rotate-and-translate vertex core.
// ----------------------------------------------------------------------------
`default_nettype none

package ertv_pkg;

  localparam int unsigned TRIG_FRAC_BITS_DEF = 15;

  // Width of the scaled and rotated vertex coordinates.
  localparam int unsigned VW = 26;

  localparam int unsigned NUM_STEPS = 3;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam logic [13:0] OCT_HALF = 14'd8192;
  localparam logic [14:0] QUAD_LEN = 15'd16384;

  localparam logic [1:0] REG_SCALE    = 2'd0;
  localparam logic [1:0] REG_OFFSET_X = 2'd1;
  localparam logic [1:0] REG_OFFSET_Y = 2'd2;
  localparam logic [1:0] REG_OFFSET_Z = 2'd3;

  localparam logic [7:0]  SCALE_RST  = 8'd60;
  localparam logic [15:0] OFFSET_RST = 16'd120;

  localparam logic [31:0] MAG_72 = 32'((64'd1 << 37) / 64'd72 + 64'd1);
  localparam logic [31:0] MAG_90 = 32'((64'd1 << 37) / 64'd90 + 64'd1);
  localparam logic [31:0] MAG_42 = 32'((64'd1 << 36) / 64'd42 + 64'd1);
  localparam logic [31:0] MAG_56 = 32'((64'd1 << 36) / 64'd56 + 64'd1);
  localparam logic [31:0] MAG_20 = 32'((64'd1 << 35) / 64'd20 + 64'd1);
  localparam logic [31:0] MAG_30 = 32'((64'd1 << 35) / 64'd30 + 64'd1);
  localparam logic [31:0] MAG_6  = 32'((64'd1 << 33) / 64'd6 + 64'd1);
  localparam logic [31:0] MAG_12 = 32'((64'd1 << 34) / 64'd12 + 64'd1);

  localparam logic [5:0] SH_72 = 6'd37;
  localparam logic [5:0] SH_90 = 6'd37;

  localparam logic [31:0] SIN_MAG [NUM_STEPS] = '{MAG_42, MAG_20, MAG_6};
  localparam logic [5:0]  SIN_SH  [NUM_STEPS] = '{6'd36, 6'd35, 6'd33};
  localparam logic [31:0] COS_MAG [NUM_STEPS] = '{MAG_56, MAG_30, MAG_12};
  localparam logic [5:0]  COS_SH  [NUM_STEPS] = '{6'd36, 6'd35, 6'd34};

  // Exact quotient of a 30-bit value by a constant, through its reciprocal.
  function automatic logic [29:0] div_mag(input logic [29:0] n, input logic [31:0] m,
                                          input logic [5:0] sh);
    logic [61:0] p;
    p = 62'(n) * 62'(m);
    return 30'(p >> sh);
  endfunction

endpackage

`default_nettype wire

@@ rtl/ertv_sincos.sv @@
// ----------------------------------------------------------------------------
// ertv_sincos
// Eleven-stage sine and cosine of a binary angle by octant folding and Horner
// evaluation of Taylor series in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module ertv_sincos #(
  parameter int unsigned TRIG_FRAC_BITS = ertv_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [15:0]                      angle,
  output logic signed [TRIG_FRAC_BITS+1:0]      sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0]      cos_o
);

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned NS = ertv_pkg::NUM_STEPS;
  localparam logic [31:0] RND = 32'(1) << (29 - TRIG_FRAC_BITS);

  logic [1:0]  q_in;
  logic [13:0] r_in;
  logic        sw_in;
  logic [13:0] n_in;

  logic [29:0] x1_r;
  logic [2:0]  meta1_r;
  logic [29:0] xa_r, xsq_r;
  logic [2:0]  meta2_r;

  logic [29:0] hx_r  [NS+1];
  logic [29:0] hx2_r [NS+1];
  logic [30:0] hts_r [NS+1];
  logic [30:0] htc_r [NS+1];
  logic [2:0]  hm_r  [NS+1];

  logic [29:0] mx_r  [NS];
  logic [29:0] mx2_r [NS];
  logic [29:0] mps_r [NS];
  logic [29:0] mpc_r [NS];
  logic [2:0]  mm_r  [NS];

  logic [29:0] fs_r, fp_r;
  logic [2:0]  fm_r;

  logic [30:0] pc_q30;
  logic signed [TW-1:0] s_rd, c_rd, s_sw, c_sw;
  logic signed [TW-1:0] sin_r, cos_r;

  assign q_in  = angle[15:14];
  assign r_in  = angle[13:0];
  assign sw_in = r_in > ertv_pkg::OCT_HALF;
  assign n_in  = sw_in ? 14'(ertv_pkg::QUAD_LEN - 15'(r_in)) : r_in;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= 30'((46'(n_in) * 46'(ertv_pkg::PI_Q30)) >> 15);
      meta1_r <= {q_in, sw_in};
      xa_r    <= x1_r;
      xsq_r   <= 30'((60'(x1_r) * 60'(x1_r)) >> 30);
      meta2_r <= meta1_r;
      hx_r[0]  <= xa_r;
      hx2_r[0] <= xsq_r;
      hts_r[0] <= ertv_pkg::Q30_ONE
                  - 31'(ertv_pkg::div_mag(xsq_r, ertv_pkg::MAG_72, ertv_pkg::SH_72));
      htc_r[0] <= ertv_pkg::Q30_ONE
                  - 31'(ertv_pkg::div_mag(xsq_r, ertv_pkg::MAG_90, ertv_pkg::SH_90));
      hm_r[0]  <= meta2_r;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        mx_r[k]  <= hx_r[k];
        mx2_r[k] <= hx2_r[k];
        mps_r[k] <= 30'((61'(hx2_r[k]) * 61'(hts_r[k])) >> 30);
        mpc_r[k] <= 30'((61'(hx2_r[k]) * 61'(htc_r[k])) >> 30);
        mm_r[k]  <= hm_r[k];
        hx_r[k+1]  <= mx_r[k];
        hx2_r[k+1] <= mx2_r[k];
        hts_r[k+1] <= ertv_pkg::Q30_ONE - 31'(ertv_pkg::div_mag(
                        mps_r[k], ertv_pkg::SIN_MAG[k], ertv_pkg::SIN_SH[k]));
        htc_r[k+1] <= ertv_pkg::Q30_ONE - 31'(ertv_pkg::div_mag(
                        mpc_r[k], ertv_pkg::COS_MAG[k], ertv_pkg::COS_SH[k]));
        hm_r[k+1]  <= mm_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs_r <= 30'((61'(hx_r[NS]) * 61'(hts_r[NS])) >> 30);
      fp_r <= 30'((61'(hx2_r[NS]) * 61'(htc_r[NS])) >> 30);
      fm_r <= hm_r[NS];
    end
  end

  always_comb begin
    pc_q30 = ertv_pkg::Q30_ONE - 31'(fp_r >> 1);
    s_rd   = TW'((32'(fs_r) + RND) >> (30 - TRIG_FRAC_BITS));
    c_rd   = TW'((32'(pc_q30) + RND) >> (30 - TRIG_FRAC_BITS));
    s_sw   = fm_r[0] ? c_rd : s_rd;
    c_sw   = fm_r[0] ? s_rd : c_rd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (fm_r[2:1])
        2'd0: begin
          sin_r <= s_sw;
          cos_r <= c_sw;
        end
        2'd1: begin
          sin_r <= c_sw;
          cos_r <= -s_sw;
        end
        2'd2: begin
          sin_r <= -s_sw;
          cos_r <= -c_sw;
        end
        default: begin
          sin_r <= -c_sw;
          cos_r <= s_sw;
        end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

`default_nettype wire

@@ rtl/ertv_rotate.sv @@
// ----------------------------------------------------------------------------
// ertv_rotate
// Two-stage plane rotation of a coordinate pair with round half up, carrying
// side data alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ertv_rotate #(
  parameter int unsigned TRIG_FRAC_BITS = ertv_pkg::TRIG_FRAC_BITS_DEF,
  parameter int unsigned SW             = 1
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [ertv_pkg::VW-1:0]        u_i,
  input  wire logic signed [ertv_pkg::VW-1:0]        v_i,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]      s_i,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]      c_i,
  input  wire logic [SW-1:0]                         side_i,
  output logic signed [ertv_pkg::VW-1:0]             u_o,
  output logic signed [ertv_pkg::VW-1:0]             v_o,
  output logic [SW-1:0]                              side_o
);

  localparam int unsigned PW = ertv_pkg::VW + TRIG_FRAC_BITS + 2;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (TRIG_FRAC_BITS - 1);

  logic signed [PW-1:0] uc_r, vs_r, us_r, vc_r;
  logic [SW-1:0]        side1_r;
  logic signed [PW:0]   su, sv;
  logic signed [ertv_pkg::VW-1:0] u_r, v_r;
  logic [SW-1:0]        side2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uc_r    <= PW'(u_i) * PW'(c_i);
      vs_r    <= PW'(v_i) * PW'(s_i);
      us_r    <= PW'(u_i) * PW'(s_i);
      vc_r    <= PW'(v_i) * PW'(c_i);
      side1_r <= side_i;
    end
  end

  always_comb begin
    su = (PW+1)'(uc_r) - (PW+1)'(vs_r) + HALF;
    sv = (PW+1)'(us_r) + (PW+1)'(vc_r) + HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r     <= ertv_pkg::VW'(su >>> TRIG_FRAC_BITS);
      v_r     <= ertv_pkg::VW'(sv >>> TRIG_FRAC_BITS);
      side2_r <= side1_r;
    end
  end

  assign u_o    = u_r;
  assign v_o    = v_r;
  assign side_o = side2_r;

endmodule

`default_nettype wire

@@ rtl/euler_rotate_translate_vertex_core.sv @@
// ----------------------------------------------------------------------------
// euler_rotate_translate_vertex_core
// Scales a vertex, rotates it about X, Y and Z and adds a per-axis offset.
// ----------------------------------------------------------------------------
// Throughput is one word per cycle while the output stage is empty or out_stall
// is low; the three eleven-stage sine and cosine units and three two-stage
// rotation units all advance together on one pipeline enable.
// Reset clears the valid bits and loads scale 60 and offsets of 120.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_rotate_translate_vertex_core #(
  parameter int unsigned TRIG_FRAC_BITS = ertv_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_vertex_x,
  input  wire logic signed [15:0] in_vertex_y,
  input  wire logic signed [15:0] in_vertex_z,
  input  wire logic [15:0]        in_angle_x,
  input  wire logic [15:0]        in_angle_y,
  input  wire logic [15:0]        in_angle_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int unsigned VW  = ertv_pkg::VW;
  localparam int unsigned TW  = TRIG_FRAC_BITS + 2;
  localparam int unsigned TRG = 11;
  localparam int unsigned LAT = TRG + 7;

  logic en;
  logic [LAT:1] vld_r;

  logic [7:0]         scale_r;
  logic signed [15:0] off_x_r, off_y_r, off_z_r;
  logic signed [VW-1:0] scl_ext;

  logic signed [VW-1:0] dx_r [TRG];
  logic signed [VW-1:0] dy_r [TRG];
  logic signed [VW-1:0] dz_r [TRG];

  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

  logic signed [VW-1:0] ax_y, ax_z;
  logic [VW+4*TW-1:0]   ax_side;
  logic signed [VW-1:0] ax_x;
  logic signed [TW-1:0] ax_sy, ax_cy, ax_sz, ax_cz;

  logic signed [VW-1:0] ay_z, ay_x;
  logic [VW+2*TW-1:0]   ay_side;
  logic signed [VW-1:0] ay_y;
  logic signed [TW-1:0] ay_sz, ay_cz;

  logic signed [VW-1:0] az_x, az_y;
  logic [VW-1:0]        az_side;

  logic signed [VW:0]   fx, fy, fz;
  logic signed [15:0]   ox_r, oy_r, oz_r;

  assign en        = !vld_r[LAT] || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ertv_pkg::SCALE_RST;
      off_x_r <= ertv_pkg::OFFSET_RST;
      off_y_r <= ertv_pkg::OFFSET_RST;
      off_z_r <= ertv_pkg::OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ertv_pkg::REG_SCALE:    scale_r <= cfg_data[7:0];
        ertv_pkg::REG_OFFSET_X: off_x_r <= cfg_data;
        ertv_pkg::REG_OFFSET_Y: off_y_r <= cfg_data;
        ertv_pkg::REG_OFFSET_Z: off_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign scl_ext = VW'(scale_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0] <= VW'(in_vertex_x) * scl_ext;
      dy_r[0] <= VW'(in_vertex_y) * scl_ext;
      dz_r[0] <= VW'(in_vertex_z) * scl_ext;
      for (int i = 1; i < TRG; i++) begin
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
        dz_r[i] <= dz_r[i-1];
      end
    end
  end

  ertv_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_x (
    .clk(clk), .en(en), .angle(in_angle_x), .sin_o(sx), .cos_o(cx)
  );
  ertv_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_y (
    .clk(clk), .en(en), .angle(in_angle_y), .sin_o(sy), .cos_o(cy)
  );
  ertv_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_z (
    .clk(clk), .en(en), .angle(in_angle_z), .sin_o(sz), .cos_o(cz)
  );

  ertv_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .SW(VW + 4 * TW)) u_rot_x (
    .clk(clk), .en(en),
    .u_i(dy_r[TRG-1]), .v_i(dz_r[TRG-1]), .s_i(sx), .c_i(cx),
    .side_i({dx_r[TRG-1], sy, cy, sz, cz}),
    .u_o(ax_y), .v_o(ax_z), .side_o(ax_side)
  );

  assign {ax_x, ax_sy, ax_cy, ax_sz, ax_cz} = ax_side;

  ertv_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .SW(VW + 2 * TW)) u_rot_y (
    .clk(clk), .en(en),
    .u_i(ax_z), .v_i(ax_x), .s_i(ax_sy), .c_i(ax_cy),
    .side_i({ax_y, ax_sz, ax_cz}),
    .u_o(ay_z), .v_o(ay_x), .side_o(ay_side)
  );

  assign {ay_y, ay_sz, ay_cz} = ay_side;

  ertv_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .SW(VW)) u_rot_z (
    .clk(clk), .en(en),
    .u_i(ay_x), .v_i(ay_y), .s_i(ay_sz), .c_i(ay_cz),
    .side_i(ay_z),
    .u_o(az_x), .v_o(az_y), .side_o(az_side)
  );

  function automatic logic signed [15:0] sat16(input logic signed [VW:0] v);
    logic signed [15:0] r;
    if (v > (VW+1)'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -(VW+1)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  always_comb begin
    fx = (VW+1)'(az_x) + (VW+1)'(off_x_r);
    fy = (VW+1)'(az_y) + (VW+1)'(off_y_r);
    fz = (VW+1)'(signed'(az_side)) + (VW+1)'(off_z_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= sat16(fx);
      oy_r <= sat16(fy);
      oz_r <= sat16(fz);
    end
  end

  assign out_valid = vld_r[LAT];
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[1])
    else $error("accepted word did not enter the pipeline");

  a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage empty");

  a_chain_advance : assert property (@(posedge clk) disable iff (!rst_n)
    en |=> out_valid == $past(vld_r[LAT-1]))
    else $error("valid chain did not advance");

  a_chain_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("held result word changed");

endmodule

`default_nettype wire
